FILE: design/rcm_pkg.sv
// Shared constants and types for the relaxed criticality block.
package rcm_pkg;

    localparam int NUM_DOMAINS_DEF    = 8;
    localparam int TIME_BITS_DEF      = 32;
    localparam int CRIT_FRAC_BITS_DEF = 16;

    localparam int PAIR_SLOTS_MAX = 64;
    localparam int DOM_W          = 3;
    localparam int IN_TIME_W      = 32;
    localparam int Q_DEPTH        = 2;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_TAG  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_SETUP,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed
    {
        logic last;
        logic missing;
    } tag_flags_t;

endpackage

FILE: design/rcm_ram.sv
// Generic single write port RAM with registered read.
module rcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rcm_front.sv
// Front end: accepts beats, keeps the pair table, looks up and shifts each tag.
module rcm_front #(
    parameter int NUM_DOMAINS = rcm_pkg::NUM_DOMAINS_DEF,
    parameter int TIME_BITS   = rcm_pkg::TIME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  func,
    input  logic [rcm_pkg::DOM_W-1:0]             launch_dom,
    input  logic [rcm_pkg::DOM_W-1:0]             capture_dom,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  slack_ps,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  required_ps,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  pair_worst_slack_ps,
    input  logic                                  last_tag,
    output logic                                  q_push,
    input  logic                                  q_full,
    output rcm_pkg::tag_flags_t                   q_flags,
    output logic signed [TIME_BITS:0]             q_req,
    output logic signed [TIME_BITS:0]             q_num
);

    localparam int SLOTS_ALL = NUM_DOMAINS * NUM_DOMAINS;
    localparam int SLOTS     = SLOTS_ALL > rcm_pkg::PAIR_SLOTS_MAX ?
                               rcm_pkg::PAIR_SLOTS_MAX : SLOTS_ALL;
    localparam int ADDR_W    = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int IDX_W     = $clog2((1 << rcm_pkg::DOM_W) * (NUM_DOMAINS + 1));

    localparam logic signed [63:0] T_MAX = (64'sd1 <<< (TIME_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] T_MIN = -T_MAX - 64'sd1;

    function automatic logic signed [TIME_BITS-1:0] sat_time(
        input logic signed [rcm_pkg::IN_TIME_W-1:0] x
    );
        logic signed [63:0] xe;
        xe = 64'(x);
        if (xe > T_MAX)
        begin
            xe = T_MAX;
        end
        else if (xe < T_MIN)
        begin
            xe = T_MIN;
        end
        return TIME_BITS'(xe);
    endfunction

    logic                         accept;
    logic [IDX_W-1:0]             idx_full;
    logic                         hit;
    logic [ADDR_W-1:0]            addr;
    logic                         is_tag;
    logic                         ram_we;
    logic                         ram_re;
    logic [2*TIME_BITS-1:0]       ram_wdata;
    logic [2*TIME_BITS-1:0]       ram_rdata;

    logic [SLOTS-1:0]             valid_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    rcm_pkg::tag_flags_t          s1_flags_reg;
    logic signed [TIME_BITS-1:0]  s1_slack_reg;

    logic signed [TIME_BITS-1:0]  rd_req;
    logic signed [TIME_BITS-1:0]  rd_worst;
    logic signed [TIME_BITS:0]    req_e;
    logic signed [TIME_BITS:0]    worst_e;
    logic signed [TIME_BITS:0]    slack_e;

    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign is_tag = (func == rcm_pkg::FUNC_TAG);

    assign idx_full = IDX_W'(launch_dom) * IDX_W'(NUM_DOMAINS) + IDX_W'(capture_dom);
    assign hit      = (IDX_W'(launch_dom) < IDX_W'(NUM_DOMAINS))
                   && (IDX_W'(capture_dom) < IDX_W'(NUM_DOMAINS))
                   && (idx_full < IDX_W'(SLOTS));
    assign addr     = idx_full[ADDR_W-1:0];

    assign ram_we    = accept && !is_tag && hit;
    assign ram_re    = accept && is_tag;
    assign ram_wdata = {sat_time(required_ps), sat_time(pair_worst_slack_ps)};

    rcm_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (SLOTS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && is_tag)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_valid_reg && !q_full)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (ram_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_tag)
        begin
            s1_flags_reg.last    <= last_tag;
            s1_flags_reg.missing <= !(hit && valid_reg[addr]);
            s1_slack_reg         <= sat_time(slack_ps);
        end
    end

    // Table data lands the cycle after the lookup; shift by the pair's negative slack.
    assign rd_req   = ram_rdata[2*TIME_BITS-1:TIME_BITS];
    assign rd_worst = ram_rdata[TIME_BITS-1:0];
    assign req_e    = (TIME_BITS+1)'(rd_req);
    assign worst_e  = (TIME_BITS+1)'(rd_worst);
    assign slack_e  = (TIME_BITS+1)'(s1_slack_reg);

    assign q_push  = s1_valid_reg;
    assign q_flags = s1_flags_reg;
    assign q_req   = worst_e[TIME_BITS] ? (req_e - worst_e) : req_e;
    // the shift cancels in the numerator
    assign q_num   = req_e - slack_e;

endmodule

FILE: design/rcm_fifo.sv
// Small register queue between the front and back ends.
module rcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rcm_pkg::Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/rcm_back.sv
// Back end: classifies a tag, runs the restoring divider, folds the run maximum.
module rcm_back #(
    parameter int TIME_BITS      = rcm_pkg::TIME_BITS_DEF,
    parameter int CRIT_FRAC_BITS = rcm_pkg::CRIT_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  rcm_pkg::tag_flags_t         q_flags,
    input  logic signed [TIME_BITS:0]   q_req,
    input  logic signed [TIME_BITS:0]   q_num,
    output logic                        empty,
    input  logic                        pop,
    output logic [CRIT_FRAC_BITS:0]     max_criticality,
    output logic                        missing_pair,
    output logic                        bad_required
);

    localparam int CW    = CRIT_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(CRIT_FRAC_BITS);
    localparam logic [CW-1:0] CRIT_ONE = CW'(1) << CRIT_FRAC_BITS;

    rcm_pkg::back_state_t        state_reg, state_next;
    rcm_pkg::tag_flags_t         item_flags_reg;
    logic signed [TIME_BITS:0]   item_req_reg;
    logic signed [TIME_BITS:0]   item_num_reg;
    logic                        load_item;

    logic [TIME_BITS:0]          rem_reg, rem_next;
    logic [CRIT_FRAC_BITS-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]               cand_reg, cand_next;
    logic [CW-1:0]               max_reg, max_next;
    logic [1:0]                  err_reg, err_next;

    logic                        out_valid_reg, out_valid_next;
    logic [CW-1:0]               out_max_reg, out_max_next;
    logic [1:0]                  out_err_reg, out_err_next;
    logic                        out_free;

    logic [TIME_BITS+1:0]        div_shift;
    logic [TIME_BITS+1:0]        div_den;
    logic                        div_ge;
    logic [CW-1:0]               fold;
    logic                        finish;

    assign out_free  = !out_valid_reg || pop;
    assign div_shift = {rem_reg, 1'b0};
    assign div_den   = {1'b0, item_req_reg};
    assign div_ge    = (div_shift >= div_den);
    assign fold      = (cand_reg > max_reg) ? cand_reg : max_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        cand_next      = cand_reg;
        max_next       = max_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !pop;
        out_max_next   = out_max_reg;
        out_err_next   = out_err_reg;
        load_item      = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            rcm_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    load_item  = 1'b1;
                    state_next = rcm_pkg::BK_SETUP;
                end
            end
            rcm_pkg::BK_SETUP:
            begin
                cand_next  = '0;
                state_next = rcm_pkg::BK_DONE;
                priority if (item_flags_reg.missing)
                begin
                    err_next[0] = 1'b1;
                end
                else if (item_req_reg <= 0)
                begin
                    err_next[1] = 1'b1;
                end
                else if (item_num_reg <= 0)
                begin
                    cand_next = '0;
                end
                else if (item_num_reg >= item_req_reg)
                begin
                    cand_next = CRIT_ONE;
                end
                else
                begin
                    rem_next   = item_num_reg;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = rcm_pkg::BK_DIV;
                end
            end
            rcm_pkg::BK_DIV:
            begin
                rem_next = div_ge ? (TIME_BITS+1)'(div_shift - div_den) : div_shift[TIME_BITS:0];
                quo_next = {quo_reg[CRIT_FRAC_BITS-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CRIT_FRAC_BITS - 1))
                begin
                    cand_next  = CW'(quo_next);
                    state_next = rcm_pkg::BK_DONE;
                end
            end
            rcm_pkg::BK_DONE:
            begin
                if (item_flags_reg.last)
                begin
                    // hold here until the result register frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_max_next   = fold;
                        out_err_next   = err_reg;
                        max_next       = '0;
                        err_next       = '0;
                        finish         = 1'b1;
                    end
                end
                else
                begin
                    max_next = fold;
                    finish   = 1'b1;
                end
                if (finish)
                begin
                    if (!q_empty)
                    begin
                        load_item  = 1'b1;
                        state_next = rcm_pkg::BK_SETUP;
                    end
                    else
                    begin
                        state_next = rcm_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rcm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcm_pkg::BK_IDLE;
            max_reg       <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        cand_reg    <= cand_next;
        out_max_reg <= out_max_next;
        out_err_reg <= out_err_next;
        if (load_item)
        begin
            item_flags_reg <= q_flags;
            item_req_reg   <= q_req;
            item_num_reg   <= q_num;
        end
    end

    assign q_pop           = load_item;
    assign empty           = !out_valid_reg;
    assign max_criticality = out_max_reg;
    assign missing_pair    = out_err_reg[0];
    assign bad_required    = out_err_reg[1];

endmodule

FILE: design/relaxed_criticality_max.sv
// Loads are accepted while full is low. A last tag's result passes the lookup register, queue,
// setup state, divider steps when divided and done state to the result register, later when
// backed up. A divided tag holds the serial restoring divider from setup to done, a skipped
// or clamped one setup and done; the queue and lookup stage take up to three tags ahead of it.
// Reset clears the pair valid bits, queues, running maximum and error flags;
// the pair table contents stay undefined and no clearing pass is needed.
module relaxed_criticality_max #(
    parameter int NUM_DOMAINS    = rcm_pkg::NUM_DOMAINS_DEF,
    parameter int TIME_BITS      = rcm_pkg::TIME_BITS_DEF,
    parameter int CRIT_FRAC_BITS = rcm_pkg::CRIT_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  func,
    input  logic [rcm_pkg::DOM_W-1:0]             launch_dom,
    input  logic [rcm_pkg::DOM_W-1:0]             capture_dom,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  slack_ps,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  required_ps,
    input  logic signed [rcm_pkg::IN_TIME_W-1:0]  pair_worst_slack_ps,
    input  logic                                  last_tag,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [CRIT_FRAC_BITS:0]               max_criticality,
    output logic                                  missing_pair,
    output logic                                  bad_required
);

    localparam int QW = $bits(rcm_pkg::tag_flags_t) + 2 * (TIME_BITS + 1);

    logic                        f_push;
    logic                        f_full;
    rcm_pkg::tag_flags_t         f_flags;
    logic signed [TIME_BITS:0]   f_req;
    logic signed [TIME_BITS:0]   f_num;
    logic [QW-1:0]               q_wr_data;
    logic [QW-1:0]               q_rd_data;
    logic                        q_empty;
    logic                        q_pop;
    rcm_pkg::tag_flags_t         b_flags;
    logic signed [TIME_BITS:0]   b_req;
    logic signed [TIME_BITS:0]   b_num;

    rcm_front #(
        .NUM_DOMAINS (NUM_DOMAINS),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .func                (func),
        .launch_dom          (launch_dom),
        .capture_dom         (capture_dom),
        .slack_ps            (slack_ps),
        .required_ps         (required_ps),
        .pair_worst_slack_ps (pair_worst_slack_ps),
        .last_tag            (last_tag),
        .q_push              (f_push),
        .q_full              (f_full),
        .q_flags             (f_flags),
        .q_req               (f_req),
        .q_num               (f_num)
    );

    assign q_wr_data = {f_flags, f_req, f_num};

    rcm_fifo #(
        .WIDTH (QW),
        .DEPTH (rcm_pkg::Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_push),
        .wr_data (q_wr_data),
        .full    (f_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign {b_flags, b_req, b_num} = q_rd_data;

    rcm_back #(
        .TIME_BITS      (TIME_BITS),
        .CRIT_FRAC_BITS (CRIT_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_flags         (b_flags),
        .q_req           (b_req),
        .q_num           (b_num),
        .empty           (empty),
        .pop             (pop),
        .max_criticality (max_criticality),
        .missing_pair    (missing_pair),
        .bad_required    (bad_required)
    );

endmodule

FILE: design/rcm_checker.sv
// Port-level checks for the relaxed criticality block, bound to the top level.
module rcm_checker #(
    parameter int CRIT_FRAC_BITS = rcm_pkg::CRIT_FRAC_BITS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [CRIT_FRAC_BITS:0]   max_criticality,
    input logic                      missing_pair,
    input logic                      bad_required
);

    localparam logic [CRIT_FRAC_BITS:0] CRIT_ONE = (CRIT_FRAC_BITS+1)'(1) << CRIT_FRAC_BITS;

    // nothing to deliver right after reset
    a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown right after reset");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(max_criticality)
                              && $stable(missing_pair) && $stable(bad_required)))
        else $error("waiting result beat changed");

    a_crit_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (max_criticality <= CRIT_ONE))
        else $error("criticality above one");

    // backpressure only builds up behind a beat taken the cycle before
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input beat");

endmodule

bind relaxed_criticality_max rcm_checker #(
    .CRIT_FRAC_BITS (CRIT_FRAC_BITS)
) u_rcm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .max_criticality (max_criticality),
    .missing_pair    (missing_pair),
    .bad_required    (bad_required)
);

FILE: test/relaxed_criticality_max_tb.sv
// Testbench for relaxed_criticality_max: directed and random runs checked against a predictor.
module relaxed_criticality_max_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DOM = rcm_pkg::NUM_DOMAINS_DEF;
    localparam int TBITS = rcm_pkg::TIME_BITS_DEF;
    localparam int QBITS = rcm_pkg::CRIT_FRAC_BITS_DEF;
    localparam int SLOTS = rcm_pkg::PAIR_SLOTS_MAX;
    localparam longint T_MAX = (longint'(1) <<< (TBITS - 1)) - 1;
    localparam longint T_MIN = -T_MAX - 1;
    localparam logic [QBITS:0] CRIT_ONE = (QBITS + 1)'(1) << QBITS;
    // a last tag can sit behind three queued tags that each hold the divider
    localparam int DRAIN_CYCLES = 4 * (QBITS + 2) + 8;

    typedef struct packed
    {
        logic [QBITS:0] crit;
        logic           missing;
        logic           bad;
    } run_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic                          func;
    logic [rcm_pkg::DOM_W-1:0]     launch_dom;
    logic [rcm_pkg::DOM_W-1:0]     capture_dom;
    logic [rcm_pkg::IN_TIME_W-1:0] slack_ps;
    logic [rcm_pkg::IN_TIME_W-1:0] required_ps;
    logic [rcm_pkg::IN_TIME_W-1:0] pair_worst_slack_ps;
    logic                          last_tag;
    logic                          empty;
    logic                          pop;
    logic [QBITS:0]                max_criticality;
    logic                          missing_pair;
    logic                          bad_required;

    relaxed_criticality_max dut (.*);

    // predictor state
    bit             pair_loaded [SLOTS];
    longint         pair_req_ps [SLOTS];
    longint         pair_worst_ps [SLOTS];
    logic [QBITS:0] run_max = '0;
    logic           run_missing = 1'b0;
    logic           run_bad = 1'b0;
    run_result_t    run_expect [$];

    int mismatches = 0;
    int results_seen = 0;
    int beats_sent = 0;
    int burst_left = 1;
    int pop_mode = 0;
    int pop_mode_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint to_ps(input logic [31:0] raw);
        longint v;
        v = longint'(signed'(raw));
        if (v > T_MAX) v = T_MAX;
        if (v < T_MIN) v = T_MIN;
        return v;
    endfunction

    function automatic int pair_slot(input logic [2:0] l, input logic [2:0] c);
        int slot;
        if (int'(l) >= NUM_DOM || int'(c) >= NUM_DOM) return -1;
        slot = int'(l) * NUM_DOM + int'(c);
        if (slot >= SLOTS) return -1;
        return slot;
    endfunction

    // restoring division, quotient truncated, 0 < num < den
    function automatic logic [QBITS:0] frac_quotient(input longint num, input longint den);
        longint         rem;
        logic [QBITS:0] q;
        rem = num;
        q = '0;
        for (int i = 0; i < QBITS; i++)
        begin
            rem = rem <<< 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem -= den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic void predict_beat(input rcm_pkg::func_t fn, input logic [2:0] l,
                                         input logic [2:0] c, input logic [31:0] slk,
                                         input logic [31:0] rq, input logic [31:0] ws,
                                         input logic last);
        int             slot;
        longint         s_ps;
        longint         r_ps;
        longint         w_ps;
        longint         num;
        logic [QBITS:0] crit;
        run_result_t    done_run;
        slot = pair_slot(l, c);
        if (fn == rcm_pkg::FUNC_LOAD)
        begin
            if (slot >= 0)
            begin
                pair_loaded[slot] = 1'b1;
                pair_req_ps[slot] = to_ps(rq);
                pair_worst_ps[slot] = to_ps(ws);
            end
            return;
        end
        if (slot < 0 || !pair_loaded[slot])
            run_missing = 1'b1;
        else
        begin
            s_ps = to_ps(slk);
            r_ps = pair_req_ps[slot];
            w_ps = pair_worst_ps[slot];
            // relax both times by the pair's negative worst slack
            if (w_ps < 0)
            begin
                s_ps -= w_ps;
                r_ps -= w_ps;
            end
            if (r_ps <= 0)
                run_bad = 1'b1;
            else
            begin
                num = r_ps - s_ps;
                if (num <= 0)
                    crit = '0;
                else if (num >= r_ps)
                    crit = CRIT_ONE;
                else
                    crit = frac_quotient(num, r_ps);
                if (crit > run_max) run_max = crit;
            end
        end
        if (last)
        begin
            done_run = '{run_max, run_missing, run_bad};
            run_expect.insert(run_expect.size(), done_run);
            run_max = '0;
            run_missing = 1'b0;
            run_bad = 1'b0;
        end
    endfunction

    task automatic idle_gap(input int n);
        @(negedge clk);
        push = 1'b0;
        func = 1'($urandom_range(0, 1));
        slack_ps = $urandom;
        last_tag = 1'($urandom_range(0, 1));
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_beat(input rcm_pkg::func_t fn, input logic [2:0] l,
                             input logic [2:0] c,
                             input logic [31:0] slk, input logic [31:0] rq,
                             input logic [31:0] ws, input logic last);
        @(negedge clk);
        push = 1'b1;
        func = fn;
        launch_dom = l;
        capture_dom = c;
        slack_ps = slk;
        required_ps = rq;
        pair_worst_slack_ps = ws;
        last_tag = last;
        forever
        begin
            @(posedge clk);
            if (!full) break;
        end
        predict_beat(fn, l, c, slk, rq, ws, last);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            idle_gap($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 25);
        end
    endtask

    task automatic load_pair(input logic [2:0] l, input logic [2:0] c,
                             input logic [31:0] rq, input logic [31:0] ws, input logic last);
        send_beat(rcm_pkg::FUNC_LOAD, l, c, $urandom, rq, ws, last);
    endtask

    task automatic send_tag(input logic [2:0] l, input logic [2:0] c,
                            input logic [31:0] slk, input logic last);
        send_beat(rcm_pkg::FUNC_TAG, l, c, slk, $urandom, $urandom, last);
    endtask

    task automatic pause_for_drain();
        @(negedge clk);
        push = 1'b0;
        wait (run_expect.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pairs with launch ^ capture == 7 are never loaded by the random part
    function automatic logic [2:0] loadable_capture(input logic [2:0] l, input logic [2:0] c);
        return ((l ^ c) == 3'd7) ? (c ^ 3'd1) : c;
    endfunction

    task automatic random_load(input logic [2:0] l, input logic [2:0] c);
        logic [31:0] rq;
        logic [31:0] ws;
        case ($urandom_range(0, 9))
            0: rq = $urandom;
            1: rq = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0000_0001;
            2: rq = -$urandom_range(0, 100);
            default: rq = $urandom_range(1, 2_000_000);
        endcase
        case ($urandom_range(0, 9))
            0: ws = $urandom;
            1, 2, 3, 4: ws = -$urandom_range(1, 500_000);
            5: ws = '0;
            default: ws = $urandom_range(0, 500_000);
        endcase
        load_pair(l, c, rq, ws, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_tag(input logic last);
        logic [2:0]  l;
        logic [2:0]  c;
        int          slot;
        longint      span;
        longint      shift;
        longint      s;
        logic [31:0] sv;
        l = 3'($urandom_range(0, 7));
        c = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 19) == 0)
            c = ~l;
        else
            c = loadable_capture(l, c);
        slot = pair_slot(l, c);
        span = 1000;
        shift = 0;
        if (slot >= 0 && pair_loaded[slot])
        begin
            shift = (pair_worst_ps[slot] < 0) ? pair_worst_ps[slot] : 0;
            span = pair_req_ps[slot] - shift;
            if (span < 1) span = 1000;
        end
        // mostly land inside (0, required) after the relaxation
        s = shift + (longint'($urandom) % (span + span / 2 + 1)) - span / 4;
        if (s > 64'sh7fff_ffff) s = 64'sh7fff_ffff;
        if (s < -64'sh8000_0000) s = -64'sh8000_0000;
        case ($urandom_range(0, 9))
            0: sv = $urandom;
            1: sv = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: sv = s[31:0];
        endcase
        send_tag(l, c, sv, last);
    endtask

    task automatic test_table_loads();
        load_pair(3'd0, 3'd0, 32'd1000, 32'd200, 1'b1);
        load_pair(3'd7, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        load_pair(3'd1, 3'd2, 32'd0, 32'd0, 1'b0);
        load_pair(3'd2, 3'd1, -32'd100, -32'd50, 1'b1);
        load_pair(3'd3, 3'd5, 32'd800, -32'd200, 1'b0);
        load_pair(3'd5, 3'd6, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    endtask

    task automatic test_criticality_range();
        send_tag(3'd0, 3'd0, 32'd1000, 1'b0);
        send_tag(3'd0, 3'd0, 32'd1500, 1'b0);
        send_tag(3'd0, 3'd0, 32'd250, 1'b0);
        send_tag(3'd0, 3'd0, -32'd5, 1'b1);
        send_tag(3'd3, 3'd5, -32'd100, 1'b1);
        send_tag(3'd7, 3'd7, 32'h8000_0000, 1'b0);
        send_tag(3'd7, 3'd7, 32'h7fff_ffff, 1'b0);
        send_tag(3'd7, 3'd7, 32'd1, 1'b1);
    endtask

    task automatic test_run_flags();
        send_tag(3'd4, 3'd4, 32'd0, 1'b1);
        send_tag(3'd1, 3'd2, 32'd0, 1'b0);
        send_tag(3'd3, 3'd5, 32'd300, 1'b0);
        send_tag(3'd2, 3'd1, 32'h7fff_ffff, 1'b1);
        send_tag(3'd5, 3'd6, 32'd0, 1'b0);
        send_tag(3'd0, 3'd7, 32'd0, 1'b1);
    endtask

    task automatic test_min_required();
        load_pair(3'd0, 3'd0, 32'd1, 32'd0, 1'b0);
        send_tag(3'd0, 3'd0, 32'd0, 1'b1);
        send_tag(3'd0, 3'd0, 32'd1, 1'b1);
    endtask

    task automatic test_random_runs(input int n_items);
        int          start;
        int          run_len;
        logic [2:0]  l;
        start = beats_sent;
        for (int s = 0; s < SLOTS; s++)
        begin
            l = 3'(s / NUM_DOM);
            if ((l ^ 3'(s % NUM_DOM)) != 3'd7) random_load(l, 3'(s % NUM_DOM));
        end
        while (beats_sent - start < n_items)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    l = 3'($urandom_range(0, 7));
                    random_load(l, loadable_capture(l, 3'($urandom_range(0, 7))));
                end
                random_tag(k == run_len - 1);
            end
            if ($urandom_range(0, 29) == 0) pause_for_drain();
        end
    endtask

    // receiver: stall pattern switches among a few modes
    always @(negedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode = $urandom_range(0, 3);
            pop_mode_left = $urandom_range(50, 300);
        end
        pop_mode_left--;
        case (pop_mode)
            0: pop = 1'b1;
            1: pop = 1'($urandom_range(0, 1));
            2: pop = ($urandom_range(0, 7) == 0);
            default: pop = ($urandom_range(0, 39) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        run_result_t got;
        run_result_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{max_criticality, missing_pair, bad_required};
            results_seen++;
            if (run_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing expected: crit %0d missing %0b bad %0b",
                             results_seen, got.crit, got.missing, got.bad);
            end
            else
            begin
                want = run_expect.pop_front();
                if (got.crit !== want.crit || got.missing !== want.missing
                    || got.bad !== want.bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: crit exp %0d got %0d,",
                                 results_seen, want.crit, got.crit,
                                 " missing exp %0b got %0b, bad exp %0b got %0b",
                                 want.missing, got.missing, want.bad, got.bad);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        func = rcm_pkg::FUNC_LOAD;
        launch_dom = '0;
        capture_dom = '0;
        slack_ps = '0;
        required_ps = '0;
        pair_worst_slack_ps = '0;
        last_tag = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_loads();
        test_criticality_range();
        test_run_flags();
        test_min_required();
        pause_for_drain();
        test_random_runs(1500);
        pause_for_drain();

        if (mismatches == 0 && run_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
